// ===== src/caet_pkg.sv =====
package caet_pkg;

  // fixed field widths
  localparam int CMD_W      = 2;
  localparam int NODE_IDX_W = 10;
  localparam int COORD_W    = 24;
  localparam int RADIUS_W   = 23;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // stream widths and field positions
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = CMD_W;
  localparam int OUT_TDATA_W = 8;
  localparam int IDX_LSB     = 0;
  localparam int POSX_LSB    = IDX_LSB + NODE_IDX_W;
  localparam int POSY_LSB    = POSX_LSB + COORD_W;
  localparam int INSIDE_LSB  = STATUS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLASSIFY = 2'd0,
    CMD_RECORD   = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_SPARE    = 2'd3
  } caet_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STILL_IN  = 2'd0,
    ST_ARRIVED   = 2'd1,
    ST_STILL_OUT = 2'd2,
    ST_LEFT      = 2'd3
  } caet_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS   = 2'd2,
    REG_NONE     = 2'd3
  } caet_reg_t;

  // load strobes for the three geometry stages
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } caet_stage_en_t;

endpackage

// ===== src/caet_geom.sv =====
module caet_geom
  import caet_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  logic                 clk,
  input  caet_stage_en_t       en,
  input  logic [COORD_W-1:0]   pos_x,
  input  logic [COORD_W-1:0]   pos_y,
  input  logic [COORD_W-1:0]   center_x,
  input  logic [COORD_W-1:0]   center_y,
  input  logic [RADIUS_W-1:0]  radius,
  output logic                 in_area
);

  localparam int CB = COORD_BITS;
  localparam int EW = (CB > COORD_W) ? CB : COORD_W;
  localparam int RW = CB - 1;
  localparam int RE = (RW > RADIUS_W) ? RW : RADIUS_W;

  logic [EW-1:0]   px_e, py_e, cx_e, cy_e;
  logic [RE-1:0]   r_e;
  logic [RW-1:0]   r_c;
  logic [CB:0]     ddx_c, ddy_c;
  logic [CB-1:0]   dx_c, dy_c;
  logic [CB-1:0]   dx_r, dy_r;
  logic [2*CB-1:0] sqx_c, sqy_c;
  logic [2*CB-1:0] sqx_r, sqy_r;
  logic [2*RW-1:0] rsq_c, rsq_r;
  logic [2*CB:0]   sum_c;
  logic            inside_c;
  logic            inside_r;

  // coordinates read as COORD_BITS-bit two's complement
  assign px_e = EW'(pos_x);
  assign py_e = EW'(pos_y);
  assign cx_e = EW'(center_x);
  assign cy_e = EW'(center_y);
  assign r_e  = RE'(radius);
  assign r_c  = r_e[RW-1:0];

  assign ddx_c = {px_e[CB-1], px_e[CB-1:0]} - {cx_e[CB-1], cx_e[CB-1:0]};
  assign ddy_c = {py_e[CB-1], py_e[CB-1:0]} - {cy_e[CB-1], cy_e[CB-1:0]};

  // magnitude always fits in CB bits
  assign dx_c = ddx_c[CB] ? CB'(-ddx_c) : ddx_c[CB-1:0];
  assign dy_c = ddy_c[CB] ? CB'(-ddy_c) : ddy_c[CB-1:0];

  assign sqx_c = dx_r * dx_r;
  assign sqy_c = dy_r * dy_r;
  assign rsq_c = r_c * r_c;

  // boundary counts as inside
  assign sum_c    = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign inside_c = (sum_c <= (2*CB+1)'(rsq_r));

  always_ff @(posedge clk) begin
    rsq_r <= rsq_c;
    if (en.ld1) begin
      dx_r <= dx_c;
      dy_r <= dy_c;
    end
    if (en.ld2) begin
      sqx_r <= sqx_c;
      sqy_r <= sqy_c;
    end
    if (en.ld3) begin
      inside_r <= inside_c;
    end
  end

  assign in_area = inside_r;

endmodule

// ===== src/caet_marks.sv =====
module caet_marks
  import caet_pkg::*;
#(
  parameter int  NODE_COUNT = 1024,
  localparam int AW         = $clog2(NODE_COUNT)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  output logic          clr_busy
);

  localparam logic [AW-1:0] LAST = AW'(NODE_COUNT - 1);

  logic          mem [NODE_COUNT];
  logic          rd_data_r;
  logic          clr_busy_r, clr_busy_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // clearing sweep after reset, one entry a cycle
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
      if (clr_cnt_r == LAST) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

// ===== src/circular_area_entry_exit_tracker_unit.sv =====
// channel  | dir | ports                         | moves
// ---------+-----+-------------------------------+---------------------------------
// in       | in  | in_tvalid/in_tready/in_tdata  | one position report per request
//          |     | in_tuser                      | command of the report
// out      | out | out_tvalid/out_tready/out_tdata | one status per report, in order
// cfg      | in  | cfg_wr_en/cfg_index/cfg_wdata | circle centre and radius writes
//
// one report a cycle is sustained while the output is not stalled; a report
// passes four register stages (difference, square, compare, status) before
// its result can be taken
// the membership marks sit in one memory read as a report enters the compare
// stage and written as it moves on to the output register; a write to the
// same node at that edge is forwarded to the report behind it
// after reset the mark memory is swept to zero, with in_tready low;
// configuration writes are taken throughout
// a stalled output holds the pipe; new requests are taken while a finished
// status waits as long as a stage behind it is free
module circular_area_entry_exit_tracker_unit
  import caet_pkg::*;
#(
  parameter int NODE_COUNT = 1024,
  parameter int COORD_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input reports
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,  // node_index[9:0], pos_x[33:10], pos_y[57:34]
  input  logic [IN_TUSER_W-1:0]  in_tuser,  // command[1:0]
  // status results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata, // status[1:0], inside_now[2]
  // configuration writes
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int IW = ((AW > NODE_IDX_W) ? AW : NODE_IDX_W) + 1;

  // configuration registers
  logic [COORD_W-1:0]  center_x_r;
  logic [COORD_W-1:0]  center_y_r;
  logic [RADIUS_W-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r   <= '0;
    end else if (cfg_wr_en) begin
      case (caet_reg_t'(cfg_index))
        REG_CENTER_X: center_x_r <= cfg_wdata[COORD_W-1:0];
        REG_CENTER_Y: center_y_r <= cfg_wdata[COORD_W-1:0];
        REG_RADIUS:   radius_r   <= cfg_wdata[RADIUS_W-1:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  // pipeline handshake: each stage loads when its successor frees up
  logic v1_r, v2_r, v3_r, vo_r;
  logic v1_nxt, v2_nxt, v3_nxt, vo_nxt;
  logic ld_o, ld3, ld2, ld1;
  logic clr_busy;
  caet_stage_en_t en;

  assign ld_o = v3_r && (!vo_r || out_tready);
  assign ld3  = v2_r && (!v3_r || ld_o);
  assign ld2  = v1_r && (!v2_r || ld3);
  assign in_tready = (!v1_r || ld2) && !clr_busy;
  assign ld1  = in_tvalid && in_tready;

  assign en.ld1 = ld1;
  assign en.ld2 = ld2;
  assign en.ld3 = ld3;

  always_comb begin
    v1_nxt = ld1 ? 1'b1 : (ld2  ? 1'b0 : v1_r);
    v2_nxt = ld2 ? 1'b1 : (ld3  ? 1'b0 : v2_r);
    v3_nxt = ld3 ? 1'b1 : (ld_o ? 1'b0 : v3_r);
    vo_nxt = ld_o ? 1'b1 : ((vo_r && out_tready) ? 1'b0 : vo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      vo_r <= vo_nxt;
    end
  end

  // node index decode; indices beyond the table are never members
  logic [IW-1:0] idx_w;
  logic          ok_in;
  logic [AW-1:0] addr_in;

  assign idx_w   = IW'(in_tdata[IDX_LSB +: NODE_IDX_W]);
  assign ok_in   = (idx_w < IW'(NODE_COUNT));
  assign addr_in = idx_w[AW-1:0];

  // report control travelling beside the geometry
  caet_cmd_t     cmd1_r, cmd2_r, cmd3_r;
  logic          ok1_r, ok2_r, ok3_r;
  logic [AW-1:0] addr1_r, addr2_r, addr3_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      cmd1_r  <= caet_cmd_t'(in_tuser);
      ok1_r   <= ok_in;
      addr1_r <= addr_in;
    end
    if (ld2) begin
      cmd2_r  <= cmd1_r;
      ok2_r   <= ok1_r;
      addr2_r <= addr1_r;
    end
    if (ld3) begin
      cmd3_r  <= cmd2_r;
      ok3_r   <= ok2_r;
      addr3_r <= addr2_r;
    end
  end

  // inside test
  logic in_area;

  caet_geom #(
    .COORD_BITS(COORD_BITS)
  ) u_geom (
    .clk      (clk),
    .en       (en),
    .pos_x    (in_tdata[POSX_LSB +: COORD_W]),
    .pos_y    (in_tdata[POSY_LSB +: COORD_W]),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .radius   (radius_r),
    .in_area  (in_area)
  );

  // membership marks: read on entry to the compare stage, written on exit from it
  logic mark_rd;
  logic wr_en;
  logic wr_val;

  assign wr_en  = ld_o && ok3_r && ((cmd3_r == CMD_RECORD) || (cmd3_r == CMD_CLEAR));
  assign wr_val = (cmd3_r == CMD_RECORD) ? in_area : 1'b0;

  caet_marks #(
    .NODE_COUNT(NODE_COUNT)
  ) u_marks (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (ld3),
    .rd_addr  (addr2_r),
    .rd_data  (mark_rd),
    .wr_en    (wr_en),
    .wr_addr  (addr3_r),
    .wr_data  (wr_val),
    .clr_busy (clr_busy)
  );

  // forward the mark written at the same edge the next report reads it
  logic fwd_hit_r, fwd_val_r;

  always_ff @(posedge clk) begin
    if (ld3) begin
      fwd_hit_r <= wr_en && (addr3_r == addr2_r);
      fwd_val_r <= wr_val;
    end
  end

  logic         was;
  caet_status_t status_c;

  assign was = ok3_r && (fwd_hit_r ? fwd_val_r : mark_rd);

  always_comb begin
    if (in_area) begin
      status_c = was ? ST_STILL_IN : ST_ARRIVED;
    end else begin
      status_c = was ? ST_LEFT : ST_STILL_OUT;
    end
  end

  // output register
  caet_status_t status_r;
  logic         inside_now_r;

  always_ff @(posedge clk) begin
    if (ld_o) begin
      status_r     <= status_c;
      inside_now_r <= in_area;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = OUT_TDATA_W'({inside_now_r, status_r});

endmodule

// ===== src/caet_checker.sv =====
module caet_checker
  import caet_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // inside flag agrees with the status code
  a_status_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[INSIDE_LSB] ==
      ((out_tdata[STATUS_W-1:0] == ST_STILL_IN) || (out_tdata[STATUS_W-1:0] == ST_ARRIVED))))
    else $error("inside flag disagrees with status");

  // nothing is shown straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  // mark sweep blocks input right after reset
  a_sweep_blocks: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !in_tready)
    else $error("input taken during mark sweep");

endmodule

bind circular_area_entry_exit_tracker_unit caet_checker u_caet_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/circular_area_entry_exit_tracker_unit_test.sv =====
module circular_area_entry_exit_tracker_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import caet_pkg::*;

  localparam int CLK_HALF    = 2;
  localparam int RESET_TICKS = 8;
  localparam int NODES       = 1024;
  // sweep of the mark memory plus ~2000 requests at the worst stall rates, many times over
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 500;
  localparam int TAIL_TICKS  = 16;

  // one expected result per accepted report
  typedef struct packed {
    caet_status_t status;
    logic         in_area;
  } status_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // node_index[9:0], pos_x[33:10], pos_y[57:34]
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;  // command[1:0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // status[1:0], inside_now[2]
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  // our own copy of the circle and of the membership marks
  logic [COORD_W-1:0]  geo_cx     = '0;
  logic [COORD_W-1:0]  geo_cy     = '0;
  logic [RADIUS_W-1:0] geo_radius = '0;
  bit                  member_mark [NODES];

  status_result_t expected_status_q [$];

  int unsigned send_idle_pct   = 10;
  int unsigned recv_stall_pct  = 30;
  int unsigned error_count     = 0;
  int unsigned reports_sent    = 0;
  int unsigned results_checked = 0;
  int unsigned arrivals_seen   = 0;
  int unsigned departures_seen = 0;
  int unsigned settings_used   = 0;
  int unsigned cycle_count     = 0;

  circular_area_entry_exit_tracker_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // exact integer distance test, the edge of the circle counts as inside
  function automatic logic in_circle(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
    longint dx;
    longint dy;
    longint r;
    dx = longint'($signed(px)) - longint'($signed(geo_cx));
    dy = longint'($signed(py)) - longint'($signed(geo_cy));
    r  = longint'(geo_radius);
    return (dx * dx + dy * dy) <= (r * r);
  endfunction

  // status of one report against the stored mark, then the mark update
  function automatic status_result_t predict_geofence(caet_cmd_t cmd,
                                                      logic [NODE_IDX_W-1:0] node,
                                                      logic [COORD_W-1:0] px,
                                                      logic [COORD_W-1:0] py);
    status_result_t res;
    logic now_in;
    logic was_in;
    now_in = in_circle(px, py);
    // a 10 bit index never goes past the 1024 marks
    was_in = member_mark[node];
    if (now_in) begin
      if (was_in) res.status = ST_STILL_IN;
      else res.status = ST_ARRIVED;
    end else begin
      if (was_in) res.status = ST_LEFT;
      else res.status = ST_STILL_OUT;
    end
    res.in_area = now_in;
    case (cmd)
      CMD_RECORD: begin
        member_mark[node] = now_in;
      end
      CMD_CLEAR: begin
        member_mark[node] = 1'b0;
      end
      default: begin
        // classify only, the spare code behaves the same
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns mismatch: %s, got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // one result per handshake, compared with the oldest pending report
  always @(posedge clk) begin
    status_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_status_q.size() == 0) begin
        report_mismatch("status with no report pending", int'(out_tdata[STATUS_W-1:0]), -1);
      end else begin
        want = expected_status_q.pop_front();
        if (out_tdata[STATUS_W-1:0] !== want.status)
          report_mismatch("status", int'(out_tdata[STATUS_W-1:0]), int'(want.status));
        if (out_tdata[INSIDE_LSB] !== want.in_area)
          report_mismatch("inside_now", int'(out_tdata[INSIDE_LSB]), int'(want.in_area));
        results_checked++;
        if (want.status == ST_ARRIVED) arrivals_seen++;
        if (want.status == ST_LEFT) departures_seen++;
      end
    end
  end

  // receiver back-pressure at the rate of the current phase
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_status_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // register write, the local copy follows the same masking as the block
  task automatic apply_reg(caet_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_CENTER_X: begin
        geo_cx = value[COORD_W-1:0];
      end
      REG_CENTER_Y: begin
        geo_cy = value[COORD_W-1:0];
      end
      REG_RADIUS: begin
        geo_radius = value[RADIUS_W-1:0];
      end
      default: begin
        // unknown index, ignored
      end
    endcase
    @(posedge clk);
  endtask

  task automatic set_geometry(logic [CFG_DATA_W-1:0] cx, logic [CFG_DATA_W-1:0] cy,
                              logic [CFG_DATA_W-1:0] rad_word);
    apply_reg(REG_CENTER_X, cx);
    apply_reg(REG_CENTER_Y, cy);
    apply_reg(REG_RADIUS, rad_word);
    settings_used++;
  endtask

  task automatic wait_idle();
    while (expected_status_q.size() != 0) @(posedge clk);
  endtask

  // one report request, with random gaps in front of it
  task automatic send_report(caet_cmd_t cmd, logic [NODE_IDX_W-1:0] node,
                             logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
    status_result_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({py, px, node});
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = predict_geofence(cmd, node, px, py);
    expected_status_q = {expected_status_q, want};
    reports_sent++;
  endtask

  task automatic stop_stream();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int rand_offset(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // mostly around the circle, some right on its edge, some anywhere at all
  function automatic void pick_position(output logic [COORD_W-1:0] px,
                                        output logic [COORD_W-1:0] py);
    int r;
    int span;
    int ofs;
    int unsigned mode;
    r    = int'(geo_radius);
    span = r + r / 4 + 2;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      px = COORD_W'($urandom);
      py = COORD_W'($urandom);
    end else if (mode < 4) begin
      // one step inside, on or one step outside the edge along an axis
      ofs = r + int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1)) ofs = -ofs;
      if ($urandom_range(0, 1)) begin
        px = geo_cx + COORD_W'(ofs);
        py = geo_cy;
      end else begin
        px = geo_cx;
        py = geo_cy + COORD_W'(ofs);
      end
    end else begin
      px = geo_cx + COORD_W'(rand_offset(span));
      py = geo_cy + COORD_W'(rand_offset(span));
    end
  endfunction

  // a phase of random traffic under one circle and one idling mix
  task automatic run_random_phase(int unsigned count, int unsigned idle_pct,
                                  int unsigned stall_pct, logic [CFG_DATA_W-1:0] cx,
                                  logic [CFG_DATA_W-1:0] cy,
                                  logic [CFG_DATA_W-1:0] rad_word);
    logic [NODE_IDX_W-1:0] pool [8];
    logic [NODE_IDX_W-1:0] node;
    logic [COORD_W-1:0]    px;
    logic [COORD_W-1:0]    py;
    caet_cmd_t             cmd;
    int unsigned           pick;
    wait_idle();
    set_geometry(cx, cy, rad_word);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    // a handful of nodes come back again and again so marks see real histories
    foreach (pool[k]) pool[k] = NODE_IDX_W'($urandom_range(0, NODES - 1));
    pool[0] = '0;
    pool[7] = NODE_IDX_W'(NODES - 1);
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) cmd = CMD_RECORD;
      else if (pick < 70) cmd = CMD_CLASSIFY;
      else if (pick < 85) cmd = CMD_CLEAR;
      else cmd = CMD_SPARE;
      if ($urandom_range(0, 9) < 7) node = pool[$urandom_range(0, 7)];
      else node = NODE_IDX_W'($urandom);
      pick_position(px, py);
      send_report(cmd, node, px, py);
    end
    stop_stream();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset geometry: centre at the origin, radius zero, so only the origin is inside
  task automatic test_zero_radius();
    send_report(CMD_CLASSIFY, 10'd0, 24'd0, 24'd0);
    send_report(CMD_CLASSIFY, 10'd0, 24'd1, 24'd0);
    send_report(CMD_RECORD,   10'd1, 24'd0, 24'd0);
    send_report(CMD_RECORD,   10'd1, 24'd0, 24'd0);
    send_report(CMD_CLASSIFY, 10'd1, 24'd0, 24'hFFFFFF);
    send_report(CMD_CLEAR,    10'd1, 24'd0, 24'd0);
    send_report(CMD_CLASSIFY, 10'd1, 24'd0, 24'd0);
    stop_stream();
  endtask

  // 3-4-5 points sit exactly on the edge; spare command leaves the mark alone
  task automatic test_circle_edge();
    wait_idle();
    // top bit of the radius write lies outside the register and must drop
    set_geometry(24'd1000, 24'(-2000), 24'h800000 | 24'd5000);
    apply_reg(REG_NONE, 24'h123456);
    send_report(CMD_RECORD,   10'h3FF, geo_cx + 24'd3000,  geo_cy + 24'd4000);
    send_report(CMD_SPARE,    10'h3FF, geo_cx + 24'd3000,  geo_cy + 24'd4001);
    send_report(CMD_SPARE,    10'h3FF, geo_cx - 24'd3000,  geo_cy - 24'd4000);
    send_report(CMD_CLASSIFY, 10'h3FF, geo_cx + 24'd5001,  geo_cy);
    send_report(CMD_CLEAR,    10'h3FF, geo_cx - 24'd5000,  geo_cy);
    send_report(CMD_RECORD,   10'h3FF, geo_cx,             geo_cy + 24'd5001);
    send_report(CMD_CLASSIFY, 10'h3FF, geo_cx,             geo_cy - 24'd5000);
    stop_stream();
  endtask

  // widest distances the coordinate range allows, with the largest radius and then radius zero
  task automatic test_coordinate_extremes();
    wait_idle();
    set_geometry(24'h800000, 24'h800000, 24'h7FFFFF);
    send_report(CMD_RECORD,   10'h2AA, 24'h7FFFFF, 24'h7FFFFF);
    send_report(CMD_RECORD,   10'h155, 24'h800000, 24'h800000);
    send_report(CMD_RECORD,   10'h155, 24'hFFFFFF, 24'h800000);
    send_report(CMD_CLASSIFY, 10'h155, 24'h000000, 24'h800000);
    stop_stream();
    wait_idle();
    set_geometry(24'h7FFFFF, 24'h7FFFFF, 24'h000000);
    send_report(CMD_CLASSIFY, 10'h2AA, 24'h800000, 24'h800000);
    send_report(CMD_RECORD,   10'h2AA, 24'h7FFFFF, 24'h7FFFFF);
    stop_stream();
  endtask

  // receiver sparse then sender sparse, then full rate on two more circles
  task automatic test_random_traffic();
    run_random_phase(PHASE_ITEMS, 21, 73, 24'($urandom), 24'($urandom),
                     24'($urandom_range(0, 4095)));
    run_random_phase(PHASE_ITEMS, 73, 21, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    run_random_phase(PHASE_ITEMS, 0, 0, 24'($urandom), 24'($urandom), 24'($urandom));
    run_random_phase(PHASE_ITEMS, 0, 0, 24'd0, 24'd0, 24'd0);
  endtask

  initial begin
    repeat (RESET_TICKS) @(posedge clk);
    rst_n <= 1'b1;
    // the first request waits out the sweep of the mark memory
    test_zero_radius();
    test_circle_edge();
    test_coordinate_extremes();
    test_random_traffic();
    wait_idle();
    repeat (TAIL_TICKS) @(posedge clk);
    $display("%0d reports over %0d circle settings, %0d statuses checked", reports_sent,
             settings_used, results_checked);
    $display("%0d arrivals and %0d departures seen, %0d mismatches", arrivals_seen,
             departures_seen, error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/caet_pkg.sv
src/caet_geom.sv
src/caet_marks.sv
src/circular_area_entry_exit_tracker_unit.sv
src/caet_checker.sv
tb/circular_area_entry_exit_tracker_unit_test.sv
